[rtl/core/ccd_zero_level_event_correction_top_defines.svh]
// Assertion macros for the zero-level event correction block.
`ifndef CCD_ZERO_LEVEL_EVENT_CORRECTION_TOP_DEFINES_SVH
`define CCD_ZERO_LEVEL_EVENT_CORRECTION_TOP_DEFINES_SVH

// Check a property on every rising clock edge, reset included.
`define CCDZL_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

// Check a property on clock edges outside of reset.
`define CCDZL_ASSERT_RUN(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

[rtl/core/ccdzl_pkg.sv]
package ccdzl_pkg;

    // item kinds
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_EVENT = 1'b1;

    // configuration register indexes
    localparam logic CFG_DATA_MODE   = 1'b0;
    localparam logic CFG_CHIP_ENABLE = 1'b1;

    // data modes; the unused codes run the nine-neighbour path without expansion
    localparam logic [1:0] MODE_FAINT  = 2'd0;
    localparam logic [1:0] MODE_BRIGHT = 2'd1;

    // error codes
    localparam logic [1:0] ERR_OK      = 2'd0;
    localparam logic [1:0] ERR_CHIP    = 2'd1;
    localparam logic [1:0] ERR_OUTSIDE = 2'd2;

    // neighbourhood
    localparam logic [3:0] NBR_CENTRE = 4'd0;
    localparam logic [3:0] NBR_LAST   = 4'd8;
    localparam logic [2:0] FULL_WEIGHT = 3'd4;

    // accumulator width, wide enough for every expanded and corrected value
    localparam int ACC_W = 18;
    typedef logic signed [ACC_W-1:0] acc_t;

    // column and row offsets of the nine neighbours, centre first, then row by row
    localparam logic signed [1:0] OFF_X [9] = '{
        2'sd0, -2'sd1, 2'sd0, 2'sd1, -2'sd1, 2'sd1, -2'sd1, 2'sd0, 2'sd1
    };
    localparam logic signed [1:0] OFF_Y [9] = '{
        2'sd0, -2'sd1, -2'sd1, -2'sd1, 2'sd0, 2'sd0, 2'sd1, 2'sd1, 2'sd1
    };

    // neighbour weights in quarters, one row per grade
    localparam logic [2:0] WEIGHT_Q [8][9] = '{
        '{3'd4, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
        '{3'd4, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
        '{3'd4, 3'd0, 3'd2, 3'd0, 3'd0, 3'd0, 3'd0, 3'd2, 3'd0},
        '{3'd4, 3'd0, 3'd0, 3'd0, 3'd4, 3'd0, 3'd0, 3'd0, 3'd0},
        '{3'd4, 3'd0, 3'd0, 3'd0, 3'd0, 3'd4, 3'd0, 3'd0, 3'd0},
        '{3'd4, 3'd0, 3'd1, 3'd0, 3'd1, 3'd1, 3'd0, 3'd1, 3'd0},
        '{3'd4, 3'd1, 3'd2, 3'd1, 3'd2, 3'd2, 3'd1, 3'd2, 3'd1},
        '{3'd4, 3'd0, 3'd2, 3'd0, 3'd2, 3'd2, 3'd0, 3'd2, 3'd0}
    };

    // piecewise expansion of a raw pulse height
    function automatic acc_t expand_pha(input logic [11:0] v);
        acc_t w;
        w = acc_t'({6'd0, v});
        if (v < 12'd1024)
            return w;
        else if (v < 12'd1536)
            return 18'sd1024 + ((w - 18'sd1024) <<< 1);
        else
            return 18'sd2048 + ((w - 18'sd1536) <<< 2);
    endfunction

    // piecewise compression back to the raw scale
    function automatic acc_t reduce_pha(input acc_t v);
        if (v < 18'sd1024)
            return v;
        else if (v < 18'sd2048)
            return 18'sd1024 + ((v - 18'sd1024) >>> 1);
        else
            return 18'sd1536 + ((v - 18'sd2048) >>> 2);
    endfunction

endpackage

[rtl/core/ccdzl_in_if.sv]
interface ccdzl_in_if;
    logic               valid;
    logic               ready;
    logic               kind;
    logic [1:0]         chip;
    logic [17:0]        map_addr;
    logic signed [11:0] map_value;
    logic [8:0]         pos_x;
    logic [8:0]         pos_y;
    logic [3:0]         pixel;
    logic [2:0]         grade;
    logic [11:0]        pha;

    modport source (
        output valid, kind, chip, map_addr, map_value, pos_x, pos_y, pixel, grade, pha,
        input  ready
    );
    modport sink (
        input  valid, kind, chip, map_addr, map_value, pos_x, pos_y, pixel, grade, pha,
        output ready
    );
endinterface

[rtl/core/ccdzl_out_if.sv]
interface ccdzl_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] pha_out;
    logic [1:0]         error_code;

    modport source (
        output valid, pha_out, error_code,
        input  ready
    );
    modport sink (
        input  valid, pha_out, error_code,
        output ready
    );
endinterface

[rtl/core/ccdzl_cfg_if.sv]
interface ccdzl_cfg_if;
    logic       valid;
    logic       ready;
    logic       index;
    logic [3:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

[rtl/core/ccd_zero_level_event_correction_top.sv]
// Channel   Modport  Transaction
// items     sink     one map load or one event (kind, chip, map_addr, map_value,
//                    pos_x, pos_y, pixel, grade, pha)
// results   source   one corrected event (pha_out, error_code)
// cfg       sink     one register write (index, data)
//
// A load is written while idle and a disabled-chip event goes straight to done;
// a faint event reads one neighbour word and any other event all nine, one per
// cycle from the single map memory port, each read followed by one accumulate step.
// Reset clears control and configuration; the map memory is not cleared.
// A finished result waits in the output register; a following item is taken
// meanwhile and stalls only when its own result finds that register still full.
`include "ccd_zero_level_event_correction_top_defines.svh"

module ccd_zero_level_event_correction_top #(
    parameter int MAP_WIDTH  = 512,
    parameter int MAP_HEIGHT = 512,
    parameter int NUM_CHIPS  = 4
) (
    input  logic       clk,
    input  logic       rst_n,
    ccdzl_in_if.sink   items,
    ccdzl_out_if.source results,
    ccdzl_cfg_if.sink  cfg
);

    localparam int MAP_WORDS = MAP_WIDTH * MAP_HEIGHT;
    localparam int MEM_DEPTH = NUM_CHIPS * MAP_WORDS;
    localparam int MEM_AW    = $clog2(MEM_DEPTH);
    localparam int CALC_W    = ((MEM_AW > 18) ? MEM_AW : 18) + 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0] state_reg, state_next;

    logic [1:0] data_mode_reg;
    logic [3:0] chip_enable_reg;

    logic [1:0]  ev_chip_reg;
    logic [8:0]  ev_x_reg;
    logic [8:0]  ev_y_reg;
    logic [3:0]  ev_pixel_reg;
    logic [2:0]  ev_grade_reg;
    logic        ev_faint_reg;
    logic        ev_bright_reg;
    logic        err_chip_reg;
    logic        outside_reg;
    logic [3:0]  issue_cnt_reg;
    logic        issue_done_reg;

    logic               rd_valid_reg;
    logic               rd_last_reg;
    logic               rd_out_reg;
    logic [2:0]         rd_w_reg;
    logic signed [11:0] mem_rdata_reg;

    ccdzl_pkg::acc_t acc_reg, acc_next;

    logic               out_valid_reg;
    logic signed [15:0] pha_out_reg;
    logic [1:0]         error_reg;

    logic signed [11:0] mem [MEM_DEPTH];

    // ---------------------------------------------------------------
    // accept and decode
    logic accept, accept_load, accept_event;
    logic chip_ok, load_ok;
    logic [CALC_W-1:0] load_addr_full;
    logic [3:0] pixel_eff;

    assign items.ready  = (state_reg == ST_IDLE);
    assign accept       = items.valid && items.ready;
    assign accept_load  = accept && (items.kind == ccdzl_pkg::KIND_LOAD);
    assign accept_event = accept && (items.kind == ccdzl_pkg::KIND_EVENT);

    assign chip_ok = ({1'b0, items.chip} < 3'(NUM_CHIPS)) && chip_enable_reg[items.chip];
    assign load_ok = ({1'b0, items.chip} < 3'(NUM_CHIPS))
                  && (CALC_W'(items.map_addr) < CALC_W'(MAP_WORDS));
    assign load_addr_full = CALC_W'(items.chip) * CALC_W'(MAP_WORDS)
                          + CALC_W'(items.map_addr);
    assign pixel_eff = (items.pixel > ccdzl_pkg::NBR_LAST) ? ccdzl_pkg::NBR_CENTRE
                                                           : items.pixel;

    // ---------------------------------------------------------------
    // neighbour address for the current step
    logic [3:0]        step_k;
    logic signed [11:0] nx, ny;
    logic              nbr_outside;
    logic [CALC_W-1:0] nbr_addr_full;
    logic              issue;
    logic              issue_last;

    assign step_k = ev_faint_reg ? ev_pixel_reg : issue_cnt_reg;
    assign nx = $signed({3'b000, ev_x_reg}) + 12'(ccdzl_pkg::OFF_X[step_k]);
    assign ny = $signed({3'b000, ev_y_reg}) + 12'(ccdzl_pkg::OFF_Y[step_k]);
    assign nbr_outside = nx[11] || (nx >= 12'(MAP_WIDTH))
                      || ny[11] || (ny >= 12'(MAP_HEIGHT));
    assign nbr_addr_full = CALC_W'(ev_chip_reg) * CALC_W'(MAP_WORDS)
                         + CALC_W'(ny[9:0]) * CALC_W'(MAP_WIDTH)
                         + CALC_W'(nx[9:0]);
    assign issue      = (state_reg == ST_RUN) && !issue_done_reg;
    assign issue_last = ev_faint_reg || (issue_cnt_reg == ccdzl_pkg::NBR_LAST);

    // ---------------------------------------------------------------
    // map memory, one port: loads write while idle, events read while running
    logic mem_we, mem_re;

    assign mem_we = accept_load && load_ok;
    assign mem_re = issue && !nbr_outside;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[load_addr_full[MEM_AW-1:0]] <= items.map_value;
        else if (mem_re)
            mem_rdata_reg <= mem[nbr_addr_full[MEM_AW-1:0]];
    end

    // ---------------------------------------------------------------
    // accumulate one weighted neighbour, truncating toward zero
    logic signed [11:0] m_val;
    logic signed [15:0] mw;
    logic signed [19:0] q, q_shr;

    always_comb
    begin
        m_val = rd_out_reg ? 12'sd0 : mem_rdata_reg;
        mw    = m_val * $signed({1'b0, rd_w_reg});
        q     = (20'(acc_reg) <<< 2) - 20'(mw);
        q_shr = q >>> 2;
        if (q[19] && (q[1:0] != 2'b00))
            q_shr = q_shr + 20'sd1;
    end

    always_comb
    begin
        acc_next = acc_reg;
        if (accept_event)
            acc_next = (data_mode_reg == ccdzl_pkg::MODE_BRIGHT)
                     ? ccdzl_pkg::expand_pha(items.pha)
                     : ccdzl_pkg::acc_t'({6'd0, items.pha});
        else if (rd_valid_reg)
            acc_next = q_shr[ccdzl_pkg::ACC_W-1:0];
    end

    // ---------------------------------------------------------------
    // sequencer
    logic out_free;
    ccdzl_pkg::acc_t fin_val;

    assign out_free = !out_valid_reg || results.ready;
    assign fin_val  = ev_bright_reg ? ccdzl_pkg::reduce_pha(acc_reg) : acc_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept_event)
                    state_next = chip_ok ? ST_RUN : ST_DONE;
            end
            ST_RUN:
            begin
                if (rd_valid_reg && rd_last_reg)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // advance control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            issue_cnt_reg  <= 4'd0;
            issue_done_reg <= 1'b0;
            rd_valid_reg   <= 1'b0;
            rd_last_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_valid_reg <= issue;
            rd_last_reg  <= issue && issue_last;
            if (accept_event)
            begin
                issue_cnt_reg  <= 4'd0;
                issue_done_reg <= 1'b0;
            end
            else if (issue)
            begin
                // hold the step count on the last neighbour
                issue_cnt_reg  <= issue_last ? issue_cnt_reg : issue_cnt_reg + 4'd1;
                issue_done_reg <= issue_last;
            end
            if ((state_reg == ST_DONE) && out_free)
                out_valid_reg <= 1'b1;
            else if (results.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // hold configuration
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_mode_reg   <= ccdzl_pkg::MODE_FAINT;
            chip_enable_reg <= 4'd0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                ccdzl_pkg::CFG_DATA_MODE:   data_mode_reg   <= cfg.data[1:0];
                ccdzl_pkg::CFG_CHIP_ENABLE: chip_enable_reg <= cfg.data;
                default:                    data_mode_reg   <= data_mode_reg;
            endcase
        end
    end

    // capture event fields and step payload
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (accept_event)
        begin
            ev_chip_reg   <= items.chip;
            ev_x_reg      <= items.pos_x;
            ev_y_reg      <= items.pos_y;
            ev_pixel_reg  <= pixel_eff;
            ev_grade_reg  <= items.grade;
            ev_faint_reg  <= (data_mode_reg == ccdzl_pkg::MODE_FAINT);
            ev_bright_reg <= (data_mode_reg == ccdzl_pkg::MODE_BRIGHT) && chip_ok;
            err_chip_reg  <= !chip_ok;
            outside_reg   <= 1'b0;
        end
        else if (issue && nbr_outside)
            outside_reg <= 1'b1;
        if (issue)
        begin
            rd_out_reg <= nbr_outside;
            rd_w_reg   <= ev_faint_reg ? ccdzl_pkg::FULL_WEIGHT
                                       : ccdzl_pkg::WEIGHT_Q[ev_grade_reg][step_k];
        end
        if ((state_reg == ST_DONE) && out_free)
        begin
            pha_out_reg <= err_chip_reg ? 16'sd0 : fin_val[15:0];
            error_reg   <= err_chip_reg ? ccdzl_pkg::ERR_CHIP
                         : (outside_reg ? ccdzl_pkg::ERR_OUTSIDE : ccdzl_pkg::ERR_OK);
        end
    end

    assign results.valid      = out_valid_reg;
    assign results.pha_out    = pha_out_reg;
    assign results.error_code = error_reg;

    // ---------------------------------------------------------------
    // checks
    `CCDZL_ASSERT_ALWAYS(a_port_excl, !(mem_we && mem_re), "map write and read collide")
    `CCDZL_ASSERT_RUN(a_read_in_run, rd_valid_reg |-> (state_reg == ST_RUN), "read outside run")
    `CCDZL_ASSERT_RUN(a_chip_err_zero, (results.valid && (results.error_code == ccdzl_pkg::ERR_CHIP)) |-> (results.pha_out == 16'sd0), "chip error with nonzero pha")
    `CCDZL_ASSERT_RUN(a_done_to_out, ((state_reg == ST_DONE) && out_free) |=> out_valid_reg, "finished event not presented")

endmodule
